>>> hdl/ebal_pkg.sv
// Shared constants and types for the edge blend alpha table block.
// No dependencies; every other file but ebal_div imports this package.
`timescale 1ns / 1ps

package ebal_pkg;

   // fixed point formats
   localparam int FRAC_BITS = 16;                   // Q0.16 positions and powers
   localparam int ONE_W     = FRAC_BITS + 1;        // holds 0..1.0 inclusive
   localparam logic [ONE_W-1:0] ONE  = ONE_W'(1) << FRAC_BITS;
   localparam logic [ONE_W-1:0] HALF = ONE_W'(1) << (FRAC_BITS - 1);

   // exponents are Q4.12, floored near 0.001
   localparam int EXP_W = 16;
   localparam logic [EXP_W-1:0] EXP_FLOOR = 16'd4;

   // log2/exp2 correction factor 11/32
   localparam logic [4:0] LOG_K = 5'd11;
   // powers with an integer part this large underflow to zero
   localparam logic [8:0] POW_LIMIT = 9'd40;

   // field and register widths
   localparam int SAMPLE_W   = 12;
   localparam int ALPHA_W    = 8;
   localparam int BYTE_W     = 8;
   localparam int ANCHOR_W   = 17;
   localparam int LUT_W      = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STRIP_START = 3'd0,
      CSR_STRIP_END   = 3'd1,
      CSR_ANCHOR      = 3'd2,
      CSR_SLOPE       = 3'd3,
      CSR_GAMMA       = 3'd4,
      CSR_LUT_SAMPLES = 3'd5
   } csr_index_type;

   // per item outcome of the strip compare
   typedef enum logic [1:0] {
      MODE_CURVE = 2'd0,
      MODE_ZERO  = 2'd1,
      MODE_FULL  = 2'd2
   } blend_mode_type;

endpackage

>>> hdl/ebal_ifs.sv
// Valid/ready channel interfaces: sample request, alpha response, register write.
// Depends on ebal_pkg for field widths.
`timescale 1ns / 1ps

interface ebal_req_if import ebal_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_index;
   modport source (output valid, output sample_index, input ready);
   modport sink   (input valid, input sample_index, output ready);
endinterface

interface ebal_rsp_if import ebal_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ALPHA_W-1:0] alpha;
   modport source (output valid, output alpha, input ready);
   modport sink   (input valid, input alpha, output ready);
endinterface

interface ebal_csr_if import ebal_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  idx;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, output idx, output wdata, input ready);
   modport sink   (input valid, input idx, input wdata, output ready);
endinterface

>>> hdl/ebal_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband tag.
// Standalone; the divisor must stay constant while beats are in flight.
`timescale 1ns / 1ps

module ebal_div #(
   parameter int NUM_W = 28,
   parameter int DEN_W = 12,
   parameter int Q_W   = 17,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [TAG_W-1:0] in_tag,
   input  logic [DEN_W-1:0] divisor,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_quo,
   output logic [TAG_W-1:0] out_tag
);

   // numerator must be below divisor << Q_W so the top part starts as a remainder
   logic [Q_W-1:0]   vld_ff;
   logic [DEN_W-1:0] rem_ff [Q_W];
   logic [Q_W-1:0]   low_ff [Q_W];
   logic [Q_W-1:0]   quo_ff [Q_W];
   logic [TAG_W-1:0] tag_ff [Q_W];

   for (genvar j = 0; j < Q_W; j++) begin : g_stage
      logic             pv;
      logic [DEN_W-1:0] prem;
      logic [Q_W-1:0]   plow;
      logic [Q_W-1:0]   pquo;
      logic [TAG_W-1:0] ptag;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             take;
      logic [DEN_W-1:0] rem_in;
      logic [Q_W-1:0]   low_in;
      logic [Q_W-1:0]   quo_in;

      if (j == 0) begin : g_first
         assign pv   = in_valid;
         assign prem = DEN_W'(in_num >> Q_W);
         assign plow = in_num[Q_W-1:0];
         assign pquo = '0;
         assign ptag = in_tag;
      end else begin : g_next
         assign pv   = vld_ff[j-1];
         assign prem = rem_ff[j-1];
         assign plow = low_ff[j-1];
         assign pquo = quo_ff[j-1];
         assign ptag = tag_ff[j-1];
      end

      // shift in next numerator bit, subtract when it fits
      assign trial  = {prem, plow[Q_W-1]};
      assign diff   = trial - {1'b0, divisor};
      assign take   = (trial >= {1'b0, divisor});
      assign rem_in = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      assign low_in = {plow[Q_W-2:0], 1'b0};
      assign quo_in = {pquo[Q_W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= pv;
         end
         if (en) begin
            rem_ff[j] <= rem_in;
            low_ff[j] <= low_in;
            quo_ff[j] <= quo_in;
            tag_ff[j] <= ptag;
         end
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign out_quo   = quo_ff[Q_W-1];
   assign out_tag   = tag_ff[Q_W-1];

endmodule

>>> hdl/ebal_pow.sv
// Six stage fixed point power u^e via log2/exp2 approximation, Q0.16 base, Q4.12 exponent.
// Depends on ebal_pkg; the exponent must stay constant while beats are in flight.
`timescale 1ns / 1ps

module ebal_pow import ebal_pkg::*; #(
   parameter int TAG_W = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [ONE_W-1:0] in_base,
   input  logic [TAG_W-1:0] in_tag,
   input  logic [EXP_W-1:0] expo,
   output logic             out_valid,
   output logic [ONE_W-1:0] out_pow,
   output logic [TAG_W-1:0] out_tag
);

   logic [5:0]       vld_ff;
   logic [TAG_W-1:0] tag_ff [6];
   logic [4:0]       zero_ff;
   logic [4:0]       full_ff;

   // stage 1: leading one and normalized fraction
   logic [3:0]  msb_in;
   logic [15:0] norm_in;
   logic [15:0] f1_in;
   logic [15:0] f1_ff;
   logic [3:0]  msb1_ff;

   always_comb begin
      msb_in = '0;
      for (int i = 0; i < 16; i++) begin
         if (in_base[i]) begin
            msb_in = 4'(i);
         end
      end
      norm_in = in_base[15:0] << (4'd15 - msb_in);
      f1_in   = {norm_in[14:0], 1'b0};
   end

   // stage 2: f * (1 - f)
   logic [ONE_W-1:0] omf;
   logic [32:0]      p1_full;
   logic [31:0]      prod1_ff;
   logic [15:0]      f2_ff;
   logic [3:0]       msb2_ff;

   assign omf     = ONE - {1'b0, f1_ff};
   assign p1_full = 33'(f1_ff) * 33'(omf);

   // stage 3: m = -log2(u)
   logic [19:0] k1;
   logic [16:0] lg_sum;
   logic [15:0] lg;
   logic [20:0] m_in;
   logic [20:0] m3_ff;

   assign k1     = 20'(prod1_ff[31:16]) * 20'(LOG_K);
   assign lg_sum = 17'(f2_ff) + 17'(k1[19:5]);
   assign lg     = lg_sum[16] ? 16'hFFFF : lg_sum[15:0];
   assign m_in   = {5'(5'd16 - {1'b0, msb2_ff}), 16'b0} - 21'(lg);

   // stage 4: scale by exponent
   logic [36:0] p_full;
   logic [8:0]  ip4_ff;
   logic [15:0] fp4_ff;

   assign p_full = 37'(m3_ff) * 37'(expo);

   // stage 5: h * (1 - h) for exp2 of the fraction
   logic [ONE_W-1:0] h_in;
   logic [ONE_W-1:0] omh;
   logic [33:0]      p2_full;
   logic [31:0]      prod2_ff;
   logic [ONE_W-1:0] h5_ff;
   logic [8:0]       ip5_ff;
   logic             fpz5_ff;

   assign h_in    = ONE - {1'b0, fp4_ff};
   assign omh     = ONE - h_in;
   assign p2_full = 34'(h_in) * 34'(omh);

   // stage 6: assemble 2^-p and apply special cases
   logic [19:0]      k2;
   logic [17:0]      e2;
   logic [ONE_W-1:0] v;
   logic [ONE_W-1:0] shifted;
   logic [ONE_W-1:0] res_in;
   logic [ONE_W-1:0] res_ff;

   always_comb begin
      k2      = 20'(prod2_ff[31:16]) * 20'(LOG_K);
      e2      = 18'(ONE) + 18'(h5_ff) - 18'(k2[19:5]);
      v       = fpz5_ff ? ONE : e2[17:1];
      shifted = v >> ip5_ff;
      if (zero_ff[4]) begin
         res_in = '0;
      end else if (full_ff[4]) begin
         res_in = ONE;
      end else if (ip5_ff >= POW_LIMIT) begin
         res_in = '0;
      end else if (shifted > ONE) begin
         res_in = ONE;
      end else begin
         res_in = shifted;
      end
   end

   // valid travels with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         for (int k = 1; k < 6; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
         zero_ff  <= {zero_ff[3:0], (in_base == '0)};
         full_ff  <= {full_ff[3:0], in_base[ONE_W-1]};
         f1_ff    <= f1_in;
         msb1_ff  <= msb_in;
         prod1_ff <= p1_full[31:0];
         f2_ff    <= f1_ff;
         msb2_ff  <= msb1_ff;
         m3_ff    <= m_in;
         ip4_ff   <= p_full[36:28];
         fp4_ff   <= p_full[27:12];
         prod2_ff <= p2_full[31:0];
         h5_ff    <= h_in;
         ip5_ff   <= ip4_ff;
         fpz5_ff  <= (fp4_ff == '0);
         res_ff   <= res_in;
      end
   end

   assign out_valid = vld_ff[5];
   assign out_pow   = res_ff;
   assign out_tag   = tag_ff[5];

endmodule

>>> hdl/edge_blend_alpha_lut.sv
// Throughput: one beat per cycle; a 17 stage and a 16 stage bit-per-stage divider
// plus two 6 stage power units set the depth, and the whole pipe holds while
// both the output register and the skid register are full.
// Reset (synchronous, active high) empties the pipe and loads register defaults.
`timescale 1ns / 1ps

module edge_blend_alpha_lut import ebal_pkg::*; #(
   parameter int MAX_SAMPLES = 4096
) (
   input  logic      clock,
   input  logic      reset,
   ebal_req_if.sink  req_if,
   ebal_rsp_if.source rsp_if,
   ebal_csr_if.sink  csr_if
);

   localparam int DEN_W  = $clog2(MAX_SAMPLES);
   localparam int NUM1_W = DEN_W + FRAC_BITS;
   localparam int CMP_W  = 18;

   // ---------------- configuration registers ----------------
   logic [BYTE_W-1:0]   start_ff;
   logic [BYTE_W-1:0]   end_ff;
   logic [ANCHOR_W-1:0] anchor_ff;
   logic [EXP_W-1:0]    slope_ff;
   logic [EXP_W-1:0]    gamma_ff;
   logic [LUT_W-1:0]    lut_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         end_ff    <= 8'd255;
         anchor_ff <= 17'd32768;
         slope_ff  <= 16'd4096;
         gamma_ff  <= 16'd4096;
         lut_ff    <= 13'd256;
      end else if (csr_if.valid) begin
         unique case (csr_if.idx)
            CSR_STRIP_START: start_ff  <= csr_if.wdata[BYTE_W-1:0];
            CSR_STRIP_END:   end_ff    <= csr_if.wdata[BYTE_W-1:0];
            CSR_ANCHOR:      anchor_ff <= csr_if.wdata[ANCHOR_W-1:0];
            CSR_SLOPE:       slope_ff  <= csr_if.wdata[EXP_W-1:0];
            CSR_GAMMA:       gamma_ff  <= csr_if.wdata[EXP_W-1:0];
            CSR_LUT_SAMPLES: lut_ff    <= csr_if.wdata[LUT_W-1:0];
            default: ;
         endcase
      end
   end

   // derived settings; the user must keep them static while beats are in flight (not enforced)
   logic [CMP_W-1:0]  cnt_lo;
   logic [CMP_W-1:0]  cnt;
   logic [DEN_W-1:0]  den;
   logic [BYTE_W-1:0] lo_b;
   logic [BYTE_W-1:0] hi_b;
   logic [ONE_W-1:0]  lo_q;
   logic [ONE_W-1:0]  hi_q;
   logic [ONE_W-1:0]  span;
   logic [ONE_W-1:0]  anc;
   logic [EXP_W-1:0]  slope_e;
   logic [EXP_W-1:0]  gamma_e;

   always_comb begin
      cnt_lo  = (lut_ff < 13'd2) ? CMP_W'(2) : CMP_W'(lut_ff);
      cnt     = (cnt_lo > CMP_W'(MAX_SAMPLES)) ? CMP_W'(MAX_SAMPLES) : cnt_lo;
      den     = DEN_W'(cnt - CMP_W'(1));
      lo_b    = (start_ff < end_ff) ? start_ff : end_ff;
      hi_b    = (start_ff < end_ff) ? end_ff : start_ff;
      // round(b * 65536 / 255) = b * 257 + (b >= 128)
      lo_q    = 17'({lo_b, lo_b}) + 17'(lo_b[7]);
      hi_q    = 17'({hi_b, hi_b}) + 17'(hi_b[7]);
      span    = hi_q - lo_q;
      anc     = (anchor_ff > ONE) ? ONE : anchor_ff;
      slope_e = (slope_ff < EXP_FLOOR) ? EXP_FLOOR : slope_ff;
      gamma_e = (gamma_ff < EXP_FLOOR) ? EXP_FLOOR : gamma_ff;
   end

   // ---------------- flow control ----------------
   logic en;
   logic skid_vld_ff;
   assign en           = !skid_vld_ff;
   assign req_if.ready = en;

   // ---------------- stage A: clamp index, build x numerator ----------------
   logic [DEN_W-1:0]  idx_c;
   logic [NUM1_W-1:0] num1_in;
   logic              a_vld_ff;
   logic [NUM1_W-1:0] num1_ff;
   logic              a_end_ff;

   assign idx_c   = (CMP_W'(req_if.sample_index) > CMP_W'(den)) ? den
                                                                : DEN_W'(req_if.sample_index);
   assign num1_in = {idx_c, FRAC_BITS'(0)} + NUM1_W'(den >> 1);

   // ---------------- divider 1: x = idx / den ----------------
   logic             d1_vld;
   logic [ONE_W-1:0] d1_quo;
   logic             d1_end;

   ebal_div #(
      .NUM_W (NUM1_W),
      .DEN_W (DEN_W),
      .Q_W   (ONE_W),
      .TAG_W (1)
   ) u_div_pos (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a_vld_ff),
      .in_num    (num1_ff),
      .in_tag    (a_end_ff),
      .divisor   (den),
      .out_valid (d1_vld),
      .out_quo   (d1_quo),
      .out_tag   (d1_end)
   );

   // ---------------- stage B: strip compare ----------------
   logic [ONE_W-1:0] x_pos;
   blend_mode_type   mode_in;
   logic             b_vld_ff;
   logic [ONE_W-1:0] n_ff;
   blend_mode_type   b_mode_ff;

   always_comb begin
      x_pos = d1_end ? ONE : d1_quo;
      if (x_pos <= lo_q) begin
         mode_in = MODE_ZERO;
      end else if (x_pos >= hi_q) begin
         mode_in = MODE_FULL;
      end else begin
         mode_in = MODE_CURVE;
      end
   end

   // ---------------- divider 2: local = (x - lo) / span ----------------
   logic                     d2_vld;
   logic [FRAC_BITS-1:0]     d2_quo;
   logic [1:0]               d2_mode;

   ebal_div #(
      .NUM_W (ONE_W + FRAC_BITS),
      .DEN_W (ONE_W),
      .Q_W   (FRAC_BITS),
      .TAG_W (2)
   ) u_div_local (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_vld_ff),
      .in_num    ({n_ff, FRAC_BITS'(0)}),
      .in_tag    (b_mode_ff),
      .divisor   (span),
      .out_valid (d2_vld),
      .out_quo   (d2_quo),
      .out_tag   (d2_mode)
   );

   // ---------------- stage C: pick curve half ----------------
   logic [ONE_W-1:0] t_pos;
   logic             sel_in;
   logic [ONE_W-1:0] u_in;
   logic             c_vld_ff;
   logic [ONE_W-1:0] u_ff;
   logic [2:0]       c_tag_ff;

   assign t_pos  = ONE - {1'b0, d2_quo};
   assign sel_in = (t_pos < HALF);
   assign u_in   = sel_in ? {t_pos[FRAC_BITS-1:0], 1'b0} : {d2_quo, 1'b0};

   // ---------------- power 1: slope ----------------
   logic             p1_vld;
   logic [ONE_W-1:0] p1_pow;
   logic [2:0]       p1_tag;

   ebal_pow #(.TAG_W(3)) u_pow_slope (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_vld_ff),
      .in_base   (u_ff),
      .in_tag    (c_tag_ff),
      .expo      (slope_e),
      .out_valid (p1_vld),
      .out_pow   (p1_pow),
      .out_tag   (p1_tag)
   );

   // ---------------- stage D: scale by anchor ----------------
   logic [ONE_W-1:0]   scale;
   logic [2*ONE_W-1:0] prod_in;
   logic               d_vld_ff;
   logic [2*ONE_W-1:0] prod_ff;
   logic [2:0]         d_tag_ff;

   assign scale   = p1_tag[0] ? anc : (ONE - anc);
   assign prod_in = (2*ONE_W)'(scale) * (2*ONE_W)'(p1_pow);

   // ---------------- stage E: curve value c ----------------
   logic [ONE_W-1:0] q_hi;
   logic [ONE_W-1:0] c_in;
   logic             e_vld_ff;
   logic [ONE_W-1:0] c_ff;
   logic [1:0]       e_mode_ff;

   assign q_hi = prod_ff[2*ONE_W-2:FRAC_BITS];
   assign c_in = d_tag_ff[0] ? q_hi : (ONE - q_hi);

   // ---------------- power 2: gamma ----------------
   logic             p2_vld;
   logic [ONE_W-1:0] p2_pow;
   logic [1:0]       p2_mode;

   ebal_pow #(.TAG_W(2)) u_pow_gamma (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (e_vld_ff),
      .in_base   ((c_ff > ONE) ? ONE : c_ff),
      .in_tag    (e_mode_ff),
      .expo      (gamma_e),
      .out_valid (p2_vld),
      .out_pow   (p2_pow),
      .out_tag   (p2_mode)
   );

   // ---------------- stage F: round to alpha ----------------
   logic [ONE_W-1:0]   inv_y;
   logic [24:0]        scaled;
   logic [ALPHA_W-1:0] alpha_in;

   always_comb begin
      inv_y  = ONE - p2_pow;
      scaled = {inv_y, 8'b0} - 25'(inv_y) + 25'(HALF);
      case (blend_mode_type'(p2_mode))
         MODE_ZERO: alpha_in = '0;
         MODE_FULL: alpha_in = '1;
         default:   alpha_in = scaled[FRAC_BITS+ALPHA_W-1:FRAC_BITS];
      endcase
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_if.valid;
         b_vld_ff <= d1_vld;
         c_vld_ff <= d2_vld;
         d_vld_ff <= p1_vld;
         e_vld_ff <= d_vld_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (en) begin
         num1_ff   <= num1_in;
         a_end_ff  <= (idx_c == den);
         n_ff      <= x_pos - lo_q;
         b_mode_ff <= mode_in;
         u_ff      <= u_in;
         c_tag_ff  <= {d2_mode, sel_in};
         prod_ff   <= prod_in;
         d_tag_ff  <= p1_tag;
         c_ff      <= c_in;
         e_mode_ff <= d_tag_ff[2:1];
      end
   end

   // ---------------- output register and skid ----------------
   logic               push;
   logic               out_vld_ff;
   logic               out_vld_in;
   logic [ALPHA_W-1:0] out_ff;
   logic [ALPHA_W-1:0] out_in;
   logic               skid_vld_in;
   logic [ALPHA_W-1:0] skid_ff;
   logic [ALPHA_W-1:0] skid_in;

   assign push = en && p2_vld;

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (out_vld_ff && rsp_if.ready) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end else if (push) begin
            out_in = alpha_in;
         end else begin
            out_vld_in = 1'b0;
         end
      end else if (!out_vld_ff) begin
         out_vld_in = push;
         out_in     = alpha_in;
      end else if (push) begin
         skid_vld_in = 1'b1;
         skid_in     = alpha_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_if.valid = out_vld_ff;
   assign rsp_if.alpha = out_ff;

   // ---------------- assertions ----------------
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid holds a beat while the output register is empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && !rsp_if.ready) |=> (skid_vld_ff && $stable(skid_ff)))
      else $error("skid beat lost while the output is stalled");

   a_skid_refill: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && rsp_if.ready) |=> (out_vld_ff && !skid_vld_ff
                                         && out_ff == $past(skid_ff)))
      else $error("skid beat not moved to the output register");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_if.ready && p2_vld && en) |=> skid_vld_ff)
      else $error("finished beat dropped at a stalled output");

endmodule
